[rtl/vna_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the vertex normal accumulator
package vna_pkg;

  localparam int VERTEX_COUNT_DEF = 4096;
  localparam int IDX_W = 12;
  localparam int POS_W = 32;
  localparam int NRM_W = 16;
  localparam int ACC_W = 24;
  localparam int MAG_W = 64;
  localparam int Q_W   = 16;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_TRI  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [63:0] LEN_SQ_MIN = 64'd268;
  localparam logic signed [ACC_W:0] ACC_MAX = 25'sd8388607;
  localparam logic signed [ACC_W:0] ACC_MIN = -25'sd8388608;

  typedef enum logic [3:0] {
    S_IDLE,
    S_T_RA,
    S_T_RB,
    S_T_RC,
    S_T_EDGE,
    S_T_MUL,
    S_T_CROSS,
    S_T_UNIT,
    S_T_ARD,
    S_T_AWR,
    S_R_RD,
    S_R_SQ,
    S_R_CHK,
    S_R_UNIT
  } vna_state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_SHIFT,
    U_SQ,
    U_SQRT,
    U_DSET,
    U_DIV,
    U_DONE
  } vna_ustate_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
  } vna_req_t;

  typedef struct packed {
    logic                done;
    logic [2:0][Q_W-1:0] q;
  } vna_rsp_t;

endpackage

[rtl/vertex_normal_accumulator.sv]
`timescale 1ns / 1ps
// vertex store with face normal accumulation and normalized read-back
//
// one command channel: an item is taken when start is high and busy is low.
// load writes a vertex position and starting normal in the accept cycle when
// its index is within the store, and leaves busy low. a triangle reads its
// three positions from the position memory, forms the edge cross product on
// one shared 32x32 multiplier, turns it into a unit normal in the iterative
// unit vector unit and then does a read-modify-write of each corner
// accumulator, one corner after the other. the unit vector unit takes up to
// 33 shift steps, 4 squaring steps, 32 square root steps and 3 x 17 divide
// steps; a degenerate triangle returns to idle after the cross product and
// leaves the accumulators as they are. a read returns one result in the
// first cycle that busy is low again: the normal is reported as is when it
// is short and normalized otherwise; a read of an index beyond the store
// reports a zero normal on the next cycle. each result is shown for one
// cycle with out_valid; the receiver cannot stall it. reset returns the
// sequencer to idle; memory contents are undefined until loaded.
module vertex_normal_accumulator #(
  parameter int VERTEX_COUNT = vna_pkg::VERTEX_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_command,
  input  logic [vna_pkg::IDX_W-1:0]          in_index_a,
  input  logic [vna_pkg::IDX_W-1:0]          in_index_b,
  input  logic [vna_pkg::IDX_W-1:0]          in_index_c,
  input  logic signed [vna_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [vna_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [vna_pkg::POS_W-1:0]   in_pos_z,
  input  logic signed [vna_pkg::NRM_W-1:0]   in_start_nx,
  input  logic signed [vna_pkg::NRM_W-1:0]   in_start_ny,
  input  logic signed [vna_pkg::NRM_W-1:0]   in_start_nz,
  output logic                               out_valid,
  output logic [vna_pkg::IDX_W-1:0]          out_vertex_out,
  output logic signed [vna_pkg::ACC_W-1:0]   out_nx,
  output logic signed [vna_pkg::ACC_W-1:0]   out_ny,
  output logic signed [vna_pkg::ACC_W-1:0]   out_nz
);

  localparam int AW = $clog2(VERTEX_COUNT);

  logic [2:0][vna_pkg::POS_W-1:0] pos_mem [VERTEX_COUNT];
  logic [2:0][vna_pkg::ACC_W-1:0] acc_mem [VERTEX_COUNT];

  vna_pkg::vna_state_t state_r, state_nxt;

  logic [vna_pkg::IDX_W-1:0]      a_r, b_r, c_r;
  logic [2:0][vna_pkg::POS_W-1:0] pos_rd_r;
  logic [2:0][vna_pkg::ACC_W-1:0] acc_rd_r;
  logic [2:0][vna_pkg::POS_W-1:0] pa_r, pb_r;
  logic [2:0][31:0]               e1_r, e2_r;
  logic signed [63:0]             p_r [6];
  logic [2:0]                     mcnt_r;
  logic [1:0]                     corner_r;
  logic [2:0][vna_pkg::Q_W-1:0]   n_r;
  vna_pkg::vna_req_t              req_r;
  logic                           u_start_r;
  vna_pkg::vna_rsp_t              u_rsp;
  logic                           out_valid_r;
  logic [vna_pkg::IDX_W-1:0]      out_vertex_r;
  logic [2:0][vna_pkg::ACC_W-1:0] out_n_r;

  logic                           accept;
  logic                           a_ok, b_ok, c_ok;
  logic                           load_we;
  logic [vna_pkg::IDX_W-1:0]      corner_idx;
  logic [AW-1:0]                  pos_raddr;
  logic [AW-1:0]                  acc_raddr;
  logic [AW-1:0]                  acc_waddr;
  logic                           acc_we;
  logic [2:0][vna_pkg::ACC_W-1:0] acc_wdata;
  logic [2:0][vna_pkg::ACC_W-1:0] acc_sat;
  logic signed [32:0]             d1 [3];
  logic signed [32:0]             d2 [3];
  logic [2:0][31:0]               e1_nxt, e2_nxt;
  logic                           big;
  logic signed [31:0]             mul_a, mul_b;
  logic signed [63:0]             mul_prod;
  logic signed [63:0]             cr [3];
  logic [2:0][63:0]               cmag;
  logic [2:0]                     cneg;
  logic                           cr_zero;
  logic [2:0][63:0]               amag;
  logic [63:0]                    sq_sum;
  logic                           norm_go;

  function automatic logic [31:0] quarter(input logic signed [32:0] d);
    logic signed [32:0] t;
    t = d[32] ? (d + 33'sd3) : d;
    return 32'(t >>> 2);
  endfunction

  assign accept  = start && !busy;
  assign a_ok    = 32'(in_index_a) < VERTEX_COUNT;
  assign b_ok    = 32'(in_index_b) < VERTEX_COUNT;
  assign c_ok    = 32'(in_index_c) < VERTEX_COUNT;
  assign load_we = accept && (in_command == vna_pkg::CMD_LOAD) && a_ok;

  always_comb begin
    unique case (corner_r)
      2'd0:    corner_idx = a_r;
      2'd1:    corner_idx = b_r;
      default: corner_idx = c_r;
    endcase
    unique case (state_r)
      vna_pkg::S_T_RB: pos_raddr = AW'(b_r);
      vna_pkg::S_T_RC: pos_raddr = AW'(c_r);
      default:         pos_raddr = AW'(a_r);
    endcase
    if (state_r == vna_pkg::S_T_ARD || state_r == vna_pkg::S_T_AWR) begin
      acc_raddr = AW'(corner_idx);
    end else begin
      acc_raddr = AW'(a_r);
    end
  end

  // saturating add of the face normal to one corner
  always_comb begin
    logic signed [vna_pkg::ACC_W:0] s;
    for (int i = 0; i < 3; i++) begin
      s = $signed({acc_rd_r[i][vna_pkg::ACC_W-1], acc_rd_r[i]})
        + $signed({{(vna_pkg::ACC_W+1-vna_pkg::Q_W){n_r[i][vna_pkg::Q_W-1]}}, n_r[i]});
      if (s > vna_pkg::ACC_MAX) begin
        acc_sat[i] = vna_pkg::ACC_MAX[vna_pkg::ACC_W-1:0];
      end else if (s < vna_pkg::ACC_MIN) begin
        acc_sat[i] = vna_pkg::ACC_MIN[vna_pkg::ACC_W-1:0];
      end else begin
        acc_sat[i] = s[vna_pkg::ACC_W-1:0];
      end
    end
  end

  assign acc_we    = load_we || (state_r == vna_pkg::S_T_AWR);
  assign acc_waddr = (state_r == vna_pkg::S_T_AWR) ? AW'(corner_idx) : AW'(in_index_a);
  assign acc_wdata = (state_r == vna_pkg::S_T_AWR) ? acc_sat :
                     {{(vna_pkg::ACC_W-vna_pkg::NRM_W){in_start_nz[vna_pkg::NRM_W-1]}},
                      in_start_nz,
                      {(vna_pkg::ACC_W-vna_pkg::NRM_W){in_start_ny[vna_pkg::NRM_W-1]}},
                      in_start_ny,
                      {(vna_pkg::ACC_W-vna_pkg::NRM_W){in_start_nx[vna_pkg::NRM_W-1]}},
                      in_start_nx};

  always_ff @(posedge clk) begin
    if (load_we) begin
      pos_mem[AW'(in_index_a)] <= {in_pos_z, in_pos_y, in_pos_x};
    end
    pos_rd_r <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    acc_rd_r <= acc_mem[acc_raddr];
  end

  // edges, with a divide by four when any component reaches 2^31
  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d1[i] = $signed({pb_r[i][31], pb_r[i]}) - $signed({pa_r[i][31], pa_r[i]});
      d2[i] = $signed({pos_rd_r[i][31], pos_rd_r[i]}) - $signed({pa_r[i][31], pa_r[i]});
      if ((d1[i][32] != d1[i][31]) || (d1[i] == {2'b11, 31'b0}) ||
          (d2[i][32] != d2[i][31]) || (d2[i] == {2'b11, 31'b0})) begin
        big = 1'b1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      e1_nxt[i] = big ? quarter(d1[i]) : d1[i][31:0];
      e2_nxt[i] = big ? quarter(d2[i]) : d2[i][31:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == vna_pkg::S_T_MUL) begin
      unique case (mcnt_r)
        3'd0:    begin mul_a = e1_r[1]; mul_b = e2_r[2]; end
        3'd1:    begin mul_a = e1_r[2]; mul_b = e2_r[1]; end
        3'd2:    begin mul_a = e1_r[2]; mul_b = e2_r[0]; end
        3'd3:    begin mul_a = e1_r[0]; mul_b = e2_r[2]; end
        3'd4:    begin mul_a = e1_r[0]; mul_b = e2_r[1]; end
        default: begin mul_a = e1_r[1]; mul_b = e2_r[0]; end
      endcase
    end else begin
      unique case (mcnt_r)
        3'd0:    mul_a = 32'($signed(acc_rd_r[0]));
        3'd1:    mul_a = 32'($signed(acc_rd_r[1]));
        default: mul_a = 32'($signed(acc_rd_r[2]));
      endcase
      mul_b = mul_a;
    end
  end

  assign mul_prod = mul_a * mul_b;

  always_comb begin
    cr[0] = p_r[0] - p_r[1];
    cr[1] = p_r[2] - p_r[3];
    cr[2] = p_r[4] - p_r[5];
    for (int i = 0; i < 3; i++) begin
      cneg[i] = cr[i][63];
      cmag[i] = cr[i][63] ? 64'(-cr[i]) : 64'(cr[i]);
      amag[i] = acc_rd_r[i][vna_pkg::ACC_W-1] ?
                (64'd0 - {{(64-vna_pkg::ACC_W){1'b1}}, acc_rd_r[i]}) :
                {{(64-vna_pkg::ACC_W){1'b0}}, acc_rd_r[i]};
    end
    cr_zero = (cmag[0] == '0) && (cmag[1] == '0) && (cmag[2] == '0);
    sq_sum  = p_r[0] + p_r[1] + p_r[2];
    norm_go = sq_sum > vna_pkg::LEN_SQ_MIN;
  end

  vna_unit u_unit (
    .clk     (clk),
    .rst_n   (rst_n),
    .u_start (u_start_r),
    .u_req   (req_r),
    .u_rsp   (u_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vna_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vna_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_command)
            vna_pkg::CMD_TRI:  if (a_ok && b_ok && c_ok) state_nxt = vna_pkg::S_T_RA;
            vna_pkg::CMD_READ: if (a_ok) state_nxt = vna_pkg::S_R_RD;
            default:           state_nxt = vna_pkg::S_IDLE;
          endcase
        end
      end
      vna_pkg::S_T_RA:    state_nxt = vna_pkg::S_T_RB;
      vna_pkg::S_T_RB:    state_nxt = vna_pkg::S_T_RC;
      vna_pkg::S_T_RC:    state_nxt = vna_pkg::S_T_EDGE;
      vna_pkg::S_T_EDGE:  state_nxt = vna_pkg::S_T_MUL;
      vna_pkg::S_T_MUL:   if (mcnt_r == 3'd5) state_nxt = vna_pkg::S_T_CROSS;
      vna_pkg::S_T_CROSS: state_nxt = cr_zero ? vna_pkg::S_IDLE : vna_pkg::S_T_UNIT;
      vna_pkg::S_T_UNIT:  if (u_rsp.done) state_nxt = vna_pkg::S_T_ARD;
      vna_pkg::S_T_ARD:   state_nxt = vna_pkg::S_T_AWR;
      vna_pkg::S_T_AWR:   state_nxt = (corner_r == 2'd2) ? vna_pkg::S_IDLE : vna_pkg::S_T_ARD;
      vna_pkg::S_R_RD:    state_nxt = vna_pkg::S_R_SQ;
      vna_pkg::S_R_SQ:    if (mcnt_r == 3'd2) state_nxt = vna_pkg::S_R_CHK;
      vna_pkg::S_R_CHK:   state_nxt = norm_go ? vna_pkg::S_R_UNIT : vna_pkg::S_IDLE;
      vna_pkg::S_R_UNIT:  if (u_rsp.done) state_nxt = vna_pkg::S_IDLE;
      default:            state_nxt = vna_pkg::S_IDLE;
    endcase
  end

  assign busy = (state_r != vna_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_start_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      u_start_r   <= ((state_r == vna_pkg::S_T_CROSS) && !cr_zero) ||
                     ((state_r == vna_pkg::S_R_CHK) && norm_go);
      out_valid_r <= (accept && (in_command == vna_pkg::CMD_READ) && !a_ok) ||
                     ((state_r == vna_pkg::S_R_CHK) && !norm_go) ||
                     ((state_r == vna_pkg::S_R_UNIT) && u_rsp.done);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_r <= in_index_a;
      b_r <= in_index_b;
      c_r <= in_index_c;
      if ((in_command == vna_pkg::CMD_READ) && !a_ok) begin
        out_vertex_r <= in_index_a;
        out_n_r      <= '0;
      end
    end
    unique case (state_r)
      vna_pkg::S_T_RB:   pa_r <= pos_rd_r;
      vna_pkg::S_T_RC:   pb_r <= pos_rd_r;
      vna_pkg::S_T_EDGE: begin
        e1_r   <= e1_nxt;
        e2_r   <= e2_nxt;
        mcnt_r <= '0;
      end
      vna_pkg::S_T_MUL, vna_pkg::S_R_SQ: begin
        p_r[mcnt_r] <= mul_prod;
        mcnt_r      <= mcnt_r + 3'd1;
      end
      vna_pkg::S_T_CROSS: begin
        req_r.mag <= cmag;
        req_r.neg <= cneg;
      end
      vna_pkg::S_T_UNIT: begin
        if (u_rsp.done) begin
          n_r      <= u_rsp.q;
          corner_r <= '0;
        end
      end
      vna_pkg::S_T_AWR:  corner_r <= corner_r + 2'd1;
      vna_pkg::S_R_RD:   mcnt_r <= '0;
      vna_pkg::S_R_CHK: begin
        req_r.mag <= amag;
        for (int i = 0; i < 3; i++) req_r.neg[i] <= acc_rd_r[i][vna_pkg::ACC_W-1];
        out_vertex_r <= a_r;
        out_n_r      <= acc_rd_r;
      end
      vna_pkg::S_R_UNIT: begin
        if (u_rsp.done) begin
          for (int i = 0; i < 3; i++) begin
            out_n_r[i] <= {{(vna_pkg::ACC_W-vna_pkg::Q_W){u_rsp.q[i][vna_pkg::Q_W-1]}},
                           u_rsp.q[i]};
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_vertex_out = out_vertex_r;
  assign out_nx         = out_n_r[0];
  assign out_ny         = out_n_r[1];
  assign out_nz         = out_n_r[2];

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while sequencer busy");

  a_unit_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    u_rsp.done |-> (state_r == vna_pkg::S_T_UNIT || state_r == vna_pkg::S_R_UNIT))
    else $error("unit vector finished with no command waiting");

  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == vna_pkg::S_T_AWR && corner_r == 2'd2) |=> state_r == vna_pkg::S_IDLE)
    else $error("triangle update did not end after third corner");

  a_unit_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    u_start_r |=> (state_r == vna_pkg::S_T_UNIT || state_r == vna_pkg::S_R_UNIT))
    else $error("unit vector started outside a wait state");

endmodule

[rtl/vna_unit.sv]
`timescale 1ns / 1ps
// unit vector unit: normalizing shift, sum of squares, square root, divide
module vna_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               u_start,
  input  vna_pkg::vna_req_t  u_req,
  output vna_pkg::vna_rsp_t  u_rsp
);

  vna_pkg::vna_ustate_t ust_r, ust_nxt;

  logic [2:0][63:0] m_r;
  logic [2:0]       neg_r;
  logic [4:0]       cnt_r;
  logic [1:0]       comp_r;
  logic [63:0]      sum_r;
  logic [59:0]      sq_r;
  logic [63:0]      x_r;
  logic [63:0]      r_r;
  logic [63:0]      bit_r;
  logic [15:0]      nlo_r;
  logic [32:0]      rem_r;
  logic [15:0]      q_r;
  logic [2:0][15:0] qo_r;

  logic        shift_hi;
  logic        shift_lo;
  logic [29:0] sq_sel;
  logic [29:0] dm_sel;
  logic [31:0] len;
  logic [63:0] root_try;
  logic [32:0] rem_try;
  logic        q_bit;
  logic [15:0] q_next;
  logic [44:0] dnum;

  assign shift_hi = (|m_r[0][63:30]) | (|m_r[1][63:30]) | (|m_r[2][63:30]);
  assign shift_lo = !((|m_r[0][63:29]) | (|m_r[1][63:29]) | (|m_r[2][63:29]));
  assign len      = r_r[31:0];
  assign root_try = r_r + bit_r;
  assign rem_try  = {rem_r[31:0], nlo_r[15]};
  assign q_bit    = rem_try >= {1'b0, len};
  assign q_next   = {q_r[14:0], q_bit};
  assign dnum     = {1'b0, dm_sel, 14'b0} + 45'(len >> 1);

  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    sq_sel = m_r[0][29:0];
      2'd1:    sq_sel = m_r[1][29:0];
      2'd2:    sq_sel = m_r[2][29:0];
      default: sq_sel = '0;
    endcase
    unique case (comp_r)
      2'd0:    dm_sel = m_r[0][29:0];
      2'd1:    dm_sel = m_r[1][29:0];
      default: dm_sel = m_r[2][29:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ust_r <= vna_pkg::U_IDLE;
    end else begin
      ust_r <= ust_nxt;
    end
  end

  always_comb begin
    ust_nxt = ust_r;
    unique case (ust_r)
      vna_pkg::U_IDLE:  if (u_start) ust_nxt = vna_pkg::U_SHIFT;
      vna_pkg::U_SHIFT: if (!shift_hi && !shift_lo) ust_nxt = vna_pkg::U_SQ;
      vna_pkg::U_SQ:    if (cnt_r == 5'd3) ust_nxt = vna_pkg::U_SQRT;
      vna_pkg::U_SQRT:  if (cnt_r == 5'd31) ust_nxt = vna_pkg::U_DSET;
      vna_pkg::U_DSET:  ust_nxt = vna_pkg::U_DIV;
      vna_pkg::U_DIV: begin
        if (cnt_r == 5'd15) begin
          ust_nxt = (comp_r == 2'd2) ? vna_pkg::U_DONE : vna_pkg::U_DSET;
        end
      end
      vna_pkg::U_DONE:  ust_nxt = vna_pkg::U_IDLE;
      default:          ust_nxt = vna_pkg::U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (ust_r)
      vna_pkg::U_IDLE: begin
        if (u_start) begin
          m_r   <= u_req.mag;
          neg_r <= u_req.neg;
        end
      end
      vna_pkg::U_SHIFT: begin
        if (shift_hi) begin
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
        end else if (shift_lo) begin
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
        end else begin
          cnt_r <= '0;
          sum_r <= '0;
        end
      end
      vna_pkg::U_SQ: begin
        sq_r <= sq_sel * sq_sel;
        if (cnt_r != 5'd0) sum_r <= sum_r + 64'(sq_r);
        if (cnt_r == 5'd3) begin
          x_r   <= sum_r + 64'(sq_r);
          r_r   <= '0;
          bit_r <= 64'd1 << 62;
          cnt_r <= '0;
        end else begin
          cnt_r <= cnt_r + 5'd1;
        end
      end
      vna_pkg::U_SQRT: begin
        if (x_r >= root_try) begin
          x_r <= x_r - root_try;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) comp_r <= '0;
      end
      vna_pkg::U_DSET: begin
        rem_r <= {4'b0, dnum[44:16]};
        nlo_r <= dnum[15:0];
        q_r   <= '0;
        cnt_r <= '0;
      end
      vna_pkg::U_DIV: begin
        rem_r <= q_bit ? (rem_try - {1'b0, len}) : rem_try;
        q_r   <= q_next;
        nlo_r <= {nlo_r[14:0], 1'b0};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd15) begin
          qo_r[comp_r] <= neg_r[comp_r] ? (16'd0 - q_next) : q_next;
          comp_r       <= comp_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign u_rsp = {(ust_r == vna_pkg::U_DONE), qo_r};

endmodule
